// ===== hw/rtl/rgb_color_key_alpha_core_assert.svh =====
// assertion macros shared by the color key core
`ifndef RGB_COLOR_KEY_ALPHA_CORE_ASSERT_SVH
`define RGB_COLOR_KEY_ALPHA_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define RCKA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rcka assertion failed");
`define RCKA_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rcka assertion failed");
`else
`define RCKA_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define RCKA_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== hw/rtl/rcka_pkg.sv =====
// types and constants of the color key core
`default_nettype none
package rcka_pkg;

   localparam int CH_W       = 8;
   localparam int FRAC_BITS  = 16;
   localparam int Q_W        = FRAC_BITS + 1;
   localparam logic [Q_W-1:0] Q_ONE = 17'h10000;
   localparam int SQ_W       = 26;
   localparam int ROOT_W     = 13;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;
   localparam logic [9:0] DIV3_MUL = 10'd683;
   localparam int DIV3_SHIFT = 11;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KEY_RED   = 3'd0,
      CSR_KEY_GREEN = 3'd1,
      CSR_KEY_BLUE  = 3'd2,
      CSR_TOLERANCE = 3'd3,
      CSR_FEATHER   = 3'd4,
      CSR_SPILL     = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      REGION_ZERO = 2'd0,
      REGION_RAMP = 2'd1,
      REGION_ONE  = 2'd2
   } region_type;

   typedef struct packed {
      logic [CH_W-1:0] red_in;
      logic [CH_W-1:0] green_in;
      logic [CH_W-1:0] blue_in;
   } req_beat_type;

   typedef struct packed {
      logic [CH_W-1:0] red_out;
      logic [CH_W-1:0] green_out;
      logic [CH_W-1:0] blue_out;
      logic [CH_W-1:0] alpha_out;
   } rsp_beat_type;

   typedef logic [Q_W-1:0] spill_tab_type [128];

   // spill strength as a q16 fraction, percent saturated at 100
   function automatic spill_tab_type build_spill_table();
      spill_tab_type t;
      int p;
      for (int i = 0; i < 128; i++) begin
         p = (i > 100) ? 100 : i;
         t[i] = Q_W'((p * 65536) / 100);
      end
      return t;
   endfunction

   localparam spill_tab_type SPILL_TABLE = build_spill_table();

endpackage
`default_nettype wire

// ===== hw/rtl/rcka_isqrt.sv =====
// pipelined integer square root, one result bit per stage
`default_nettype none
module rcka_isqrt #(
   parameter int SIDE_W = 40
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          en,
   input  wire logic                          src_valid,
   input  wire logic [rcka_pkg::SQ_W-1:0]     src_value,
   input  wire logic [SIDE_W-1:0]             src_side,
   output logic                               dst_valid,
   output logic [rcka_pkg::ROOT_W-1:0]        dst_root,
   output logic [SIDE_W-1:0]                  dst_side
);
   localparam int RW  = rcka_pkg::ROOT_W;
   localparam int REM_W = RW + 3;

   logic                        valid_ff [RW];
   logic [RW-1:0]               root_ff  [RW];
   logic [REM_W-1:0]            rem_ff   [RW];
   logic [rcka_pkg::SQ_W-1:0]   val_ff   [RW];
   logic [SIDE_W-1:0]           side_ff  [RW];

   for (genvar k = 0; k < RW; k++) begin : g_stage
      logic                      valid_prev;
      logic [RW-1:0]             root_prev;
      logic [REM_W-1:0]          rem_prev;
      logic [rcka_pkg::SQ_W-1:0] val_prev;
      logic [SIDE_W-1:0]         side_prev;
      logic [REM_W-1:0]          rem_sh;
      logic [REM_W-1:0]          trial;
      logic [REM_W-1:0]          rem_in;
      logic [RW-1:0]             root_in;

      if (k == 0) begin : g_first
         assign valid_prev = src_valid;
         assign root_prev  = '0;
         assign rem_prev   = '0;
         assign val_prev   = src_value;
         assign side_prev  = src_side;
      end else begin : g_next
         assign valid_prev = valid_ff[k-1];
         assign root_prev  = root_ff[k-1];
         assign rem_prev   = rem_ff[k-1];
         assign val_prev   = val_ff[k-1];
         assign side_prev  = side_ff[k-1];
      end

      // bring down the next two radicand bits and try root*4+1
      always_comb begin
         rem_sh = {rem_prev[REM_W-3:0], val_prev[2*(RW-1-k) +: 2]};
         trial  = REM_W'({root_prev, 2'b01});
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_prev[RW-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_prev[RW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            root_ff[k] <= root_in;
            rem_ff[k]  <= rem_in;
            val_ff[k]  <= val_prev;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign dst_valid = valid_ff[RW-1];
   assign dst_root  = root_ff[RW-1];
   assign dst_side  = side_ff[RW-1];

endmodule
`default_nettype wire

// ===== hw/rtl/rcka_frac_div.sv =====
// pipelined q16 fraction divider for num <= den, one quotient bit per stage
`default_nettype none
module rcka_frac_div #(
   parameter int W      = 12,
   parameter int SIDE_W = 24
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       en,
   input  wire logic                       src_valid,
   input  wire logic [W-1:0]               src_num,
   input  wire logic [W-1:0]               src_den,
   input  wire logic [SIDE_W-1:0]          src_side,
   output logic                            dst_valid,
   output logic [rcka_pkg::Q_W-1:0]        dst_quo,
   output logic [SIDE_W-1:0]               dst_side
);
   localparam int QW = rcka_pkg::Q_W;

   logic              valid_ff [QW];
   logic [W:0]        rem_ff   [QW];
   logic [W-1:0]      den_ff   [QW];
   logic [QW-1:0]     quo_ff   [QW];
   logic [SIDE_W-1:0] side_ff  [QW];

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic              valid_prev;
      logic [W:0]        rem_sh;
      logic [W-1:0]      den_prev;
      logic [QW-1:0]     quo_prev;
      logic [SIDE_W-1:0] side_prev;
      logic [W:0]        rem_in;
      logic [QW-1:0]     quo_in;

      if (k == 0) begin : g_first
         // integer bit: no doubling on the first step
         assign valid_prev = src_valid;
         assign rem_sh     = {1'b0, src_num};
         assign den_prev   = src_den;
         assign quo_prev   = '0;
         assign side_prev  = src_side;
      end else begin : g_next
         assign valid_prev = valid_ff[k-1];
         assign rem_sh     = {rem_ff[k-1][W-1:0], 1'b0};
         assign den_prev   = den_ff[k-1];
         assign quo_prev   = quo_ff[k-1];
         assign side_prev  = side_ff[k-1];
      end

      always_comb begin
         if (rem_sh >= {1'b0, den_prev}) begin
            rem_in = rem_sh - {1'b0, den_prev};
            quo_in = {quo_prev[QW-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_prev[QW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            den_ff[k]  <= den_prev;
            quo_ff[k]  <= quo_in;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign dst_valid = valid_ff[QW-1];
   assign dst_quo   = quo_ff[QW-1];
   assign dst_side  = side_ff[QW-1];

endmodule
`default_nettype wire

// ===== hw/rtl/rgb_color_key_alpha_core.sv =====
// Euclidean rgb color key with feathered alpha and spill suppression
// pipeline: 37 register stages from the accepted req beat to rsp_valid
// throughput: one pixel per cycle; the whole pipeline advances together and holds
// only while a finished rsp beat is not taken
// reset: synchronous, clears all valid bits and loads the register defaults
`default_nettype none
`include "rgb_color_key_alpha_core_assert.svh"
module rgb_color_key_alpha_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire rcka_pkg::req_beat_type               req_beat,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output rcka_pkg::rsp_beat_type                    rsp_beat,
   input  wire logic                                 csr_we,
   input  wire logic [rcka_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [rcka_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   localparam int QW   = rcka_pkg::Q_W;
   localparam int RW   = rcka_pkg::ROOT_W;
   localparam int NUMW = 29;

   // configuration
   logic [7:0]  key_red_ff, key_green_ff, key_blue_ff;
   logic [11:0] tolerance_ff;
   logic [10:0] feather_ff;
   logic [6:0]  spill_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_red_ff   <= 8'd0;
         key_green_ff <= 8'd255;
         key_blue_ff  <= 8'd0;
         tolerance_ff <= 12'd400;
         feather_ff   <= 11'd0;
         spill_ff     <= 7'd0;
      end else if (csr_we) begin
         case (csr_index)
            rcka_pkg::CSR_KEY_RED:   key_red_ff   <= csr_wdata[7:0];
            rcka_pkg::CSR_KEY_GREEN: key_green_ff <= csr_wdata[7:0];
            rcka_pkg::CSR_KEY_BLUE:  key_blue_ff  <= csr_wdata[7:0];
            rcka_pkg::CSR_TOLERANCE: tolerance_ff <= csr_wdata[11:0];
            rcka_pkg::CSR_FEATHER:   feather_ff   <= csr_wdata[10:0];
            rcka_pkg::CSR_SPILL:     spill_ff     <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   logic pipe_en;
   logic out_valid_ff;

   assign pipe_en   = !out_valid_ff || rsp_ready;
   assign req_ready = pipe_en;

   // stage 1: input register
   logic                   s1_valid_ff;
   rcka_pkg::req_beat_type s1_beat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s1_beat_ff <= req_beat;
      end
   end

   // stage 2: squared distance, channel max and min
   logic [7:0]  ad_r, ad_g, ad_b;
   logic [17:0] sq_in;
   logic [7:0]  mx_in, mn_in;

   always_comb begin
      ad_r = (s1_beat_ff.red_in >= key_red_ff) ? s1_beat_ff.red_in - key_red_ff
                                               : key_red_ff - s1_beat_ff.red_in;
      ad_g = (s1_beat_ff.green_in >= key_green_ff) ? s1_beat_ff.green_in - key_green_ff
                                                   : key_green_ff - s1_beat_ff.green_in;
      ad_b = (s1_beat_ff.blue_in >= key_blue_ff) ? s1_beat_ff.blue_in - key_blue_ff
                                                 : key_blue_ff - s1_beat_ff.blue_in;
      sq_in = 18'(ad_r * ad_r) + 18'(ad_g * ad_g) + 18'(ad_b * ad_b);
      mx_in = s1_beat_ff.red_in;
      mn_in = s1_beat_ff.red_in;
      if (s1_beat_ff.green_in > mx_in) mx_in = s1_beat_ff.green_in;
      if (s1_beat_ff.blue_in > mx_in)  mx_in = s1_beat_ff.blue_in;
      if (s1_beat_ff.green_in < mn_in) mn_in = s1_beat_ff.green_in;
      if (s1_beat_ff.blue_in < mn_in)  mn_in = s1_beat_ff.blue_in;
   end

   logic        s2_valid_ff;
   logic [17:0] s2_sq_ff;
   logic [39:0] s2_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s2_sq_ff   <= sq_in;
         s2_side_ff <= {s1_beat_ff, mx_in, mn_in};
      end
   end

   // distance in 1/16 units
   logic          sq_dv;
   logic [RW-1:0] dist_root;
   logic [39:0]   sq_side;

   rcka_isqrt #(.SIDE_W(40)) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .src_valid (s2_valid_ff),
      .src_value ({s2_sq_ff, 8'h00}),
      .src_side  (s2_side_ff),
      .dst_valid (sq_dv),
      .dst_root  (dist_root),
      .dst_side  (sq_side)
   );

   // stage 3: ramp region and divider operands
   logic [23:0]          s3_rgb;
   logic [7:0]           s3_mx, s3_mn, s3_mxd;
   logic signed [13:0]   lo_s, dist_s, ramp_off;
   logic [12:0]          hi;
   rcka_pkg::region_type region_in;
   logic [11:0]          anum_in, aden_in;
   logic [7:0]           sden_in;
   logic                 sat_ok_in;
   logic [11:0]          mxd10;

   always_comb begin
      s3_rgb   = sq_side[39:16];
      s3_mx    = sq_side[15:8];
      s3_mn    = sq_side[7:0];
      s3_mxd   = s3_mx - s3_mn;
      lo_s     = $signed({2'b00, tolerance_ff}) - $signed({3'b000, feather_ff});
      hi       = {1'b0, tolerance_ff} + {2'b00, feather_ff};
      dist_s   = $signed({1'b0, dist_root});
      ramp_off = dist_s - lo_s;
      if (dist_s <= lo_s) begin
         region_in = rcka_pkg::REGION_ZERO;
      end else if ({1'b0, dist_root} <= {1'b0, hi} && feather_ff != 11'd0) begin
         region_in = rcka_pkg::REGION_RAMP;
      end else begin
         region_in = rcka_pkg::REGION_ONE;
      end
      anum_in = (region_in == rcka_pkg::REGION_RAMP) ? ramp_off[11:0] : 12'd0;
      aden_in = (feather_ff != 11'd0) ? {feather_ff, 1'b0} : 12'd1;
      mxd10   = {s3_mxd, 3'b000} + {3'b000, s3_mxd, 1'b0};
      // saturation above 0.1, tested exactly
      sat_ok_in = (s3_mx != 8'd0) && (mxd10 > {4'b0000, s3_mx});
      sden_in   = (s3_mx != 8'd0) ? s3_mx : 8'd1;
   end

   logic        s3_valid_ff;
   logic [11:0] s3_anum_ff, s3_aden_ff;
   logic [7:0]  s3_snum_ff, s3_sden_ff;
   logic [2:0]  s3_flag_ff;
   logic [23:0] s3_rgb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s3_valid_ff <= sq_dv;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s3_anum_ff <= anum_in;
         s3_aden_ff <= aden_in;
         s3_snum_ff <= s3_mxd;
         s3_sden_ff <= sden_in;
         s3_flag_ff <= {region_in, sat_ok_in};
         s3_rgb_ff  <= s3_rgb;
      end
   end

   // alpha ramp and saturation dividers run side by side
   logic          alpha_dv, sat_dv;
   logic [QW-1:0] ramp_q, sat_q;
   logic [23:0]   div_rgb;
   logic [2:0]    div_flag;

   rcka_frac_div #(.W(12), .SIDE_W(24)) u_alpha_div (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .src_valid (s3_valid_ff),
      .src_num   (s3_anum_ff),
      .src_den   (s3_aden_ff),
      .src_side  (s3_rgb_ff),
      .dst_valid (alpha_dv),
      .dst_quo   (ramp_q),
      .dst_side  (div_rgb)
   );

   rcka_frac_div #(.W(8), .SIDE_W(3)) u_sat_div (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .src_valid (s3_valid_ff),
      .src_num   (s3_snum_ff),
      .src_den   (s3_sden_ff),
      .src_side  (s3_flag_ff),
      .dst_valid (sat_dv),
      .dst_quo   (sat_q),
      .dst_side  (div_flag)
   );

   // stage 4: alpha select, sat * spill
   rcka_pkg::region_type div_region;
   logic [QW-1:0]        alpha_in, spill_q;
   logic [33:0]          ss_full;
   logic                 apply_in;

   always_comb begin
      div_region = rcka_pkg::region_type'(div_flag[2:1]);
      case (div_region)
         rcka_pkg::REGION_ZERO: alpha_in = '0;
         rcka_pkg::REGION_RAMP: alpha_in = ramp_q;
         rcka_pkg::REGION_ONE:  alpha_in = rcka_pkg::Q_ONE;
         default:               alpha_in = rcka_pkg::Q_ONE;
      endcase
      spill_q  = rcka_pkg::SPILL_TABLE[spill_ff];
      ss_full  = sat_q * spill_q;
      apply_in = (spill_ff != 7'd0) && (alpha_in != rcka_pkg::Q_ONE) && div_flag[0];
   end

   logic          s4_valid_ff;
   logic [QW-1:0] s4_alpha_ff, s4_ss_ff;
   logic          s4_apply_ff;
   logic [23:0]   s4_rgb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s4_valid_ff <= alpha_dv;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s4_alpha_ff <= alpha_in;
         s4_ss_ff    <= ss_full[32:16];
         s4_apply_ff <= apply_in;
         s4_rgb_ff   <= div_rgb;
      end
   end

   // stage 5: desat = ss * (1 - alpha), and the channel sum
   logic [33:0] desat_full;
   logic [9:0]  sum_in;

   always_comb begin
      desat_full = s4_ss_ff * (rcka_pkg::Q_ONE - s4_alpha_ff);
      sum_in     = 10'(s4_rgb_ff[23:16]) + 10'(s4_rgb_ff[15:8]) + 10'(s4_rgb_ff[7:0]);
   end

   logic          s5_valid_ff;
   logic [QW-1:0] s5_desat_ff, s5_alpha_ff;
   logic          s5_apply_ff;
   logic [23:0]   s5_rgb_ff;
   logic [9:0]    s5_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s5_desat_ff <= desat_full[32:16];
         s5_alpha_ff <= s4_alpha_ff;
         s5_apply_ff <= s4_apply_ff;
         s5_rgb_ff   <= s4_rgb_ff;
         s5_sum_ff   <= sum_in;
      end
   end

   // stage 6: per channel 3*c + (sum - 3*c) * desat, in q16
   logic                   s6_valid_ff;
   logic signed [NUMW-1:0] s6_num_ff [3];
   logic [7:0]             s6_chan_ff [3];
   logic                   s6_apply_ff;
   logic [QW-1:0]          s6_alpha_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s6_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s6_apply_ff <= s5_apply_ff;
         s6_alpha_ff <= s5_alpha_ff;
      end
   end

   // stage 7: clamp, divide by 3 * 65536, clamp to 255, or pass the channel through when spill is not applied
   logic [7:0] chan_out [3];

   for (genvar c = 0; c < 3; c++) begin : g_chan
      logic [7:0]             chan;
      logic [9:0]             c3;
      logic signed [10:0]     dev;
      logic signed [NUMW-1:0] prod;
      logic signed [NUMW-1:0] num_in;
      logic [10:0]            whole;
      logic [20:0]            third_full;
      logic [9:0]             third;

      assign chan = s5_rgb_ff[16-8*c +: 8];

      always_comb begin
         c3     = {chan, 1'b0} + {2'b00, chan};
         dev    = $signed({1'b0, s5_sum_ff}) - $signed({1'b0, c3});
         prod   = NUMW'(dev * $signed({1'b0, s5_desat_ff}));
         num_in = $signed(NUMW'({c3, 16'h0000})) + prod;
      end

      always_ff @(posedge clock) begin
         if (pipe_en) begin
            s6_num_ff[c]  <= num_in;
            s6_chan_ff[c] <= chan;
         end
      end

      always_comb begin
         whole      = s6_num_ff[c][NUMW-1] ? 11'd0 : s6_num_ff[c][26:16];
         third_full = whole * rcka_pkg::DIV3_MUL;
         third      = third_full[20:rcka_pkg::DIV3_SHIFT];
         if (!s6_apply_ff) begin
            chan_out[c] = s6_chan_ff[c];
         end else if (third > 10'd255) begin
            chan_out[c] = 8'd255;
         end else begin
            chan_out[c] = third[7:0];
         end
      end
   end

   logic [24:0] alpha_scaled;
   assign alpha_scaled = {s6_alpha_ff, 8'h00} - {8'h00, s6_alpha_ff};

   rcka_pkg::rsp_beat_type out_beat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         out_valid_ff <= s6_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         out_beat_ff.red_out   <= chan_out[0];
         out_beat_ff.green_out <= chan_out[1];
         out_beat_ff.blue_out  <= chan_out[2];
         out_beat_ff.alpha_out <= alpha_scaled[23:16];
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_beat  = out_beat_ff;

   // both dividers advance in lockstep
   `RCKA_ASSERT_IMP(a_div_lockstep, clock, reset, 1'b1, alpha_dv == sat_dv)
   `RCKA_ASSERT_IMP(a_alpha_range, clock, reset, s4_valid_ff, s4_alpha_ff <= rcka_pkg::Q_ONE)
   `RCKA_ASSERT_IMP(a_no_spill_opaque, clock, reset,
                    s5_valid_ff && s5_alpha_ff == rcka_pkg::Q_ONE, !s5_apply_ff)
   `RCKA_ASSERT_NXT(a_stall_holds, clock, reset, !pipe_en, $stable(s5_desat_ff))

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// self-checking testbench of the rgb color key core
`timescale 1ns / 100ps
`default_nettype none
module tb;

   localparam int LATENCY   = 37;
   localparam int WDOG_MAX  = 4000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   rcka_pkg::req_beat_type req_beat = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rcka_pkg::rsp_beat_type rsp_beat;
   logic csr_we = 1'b0;
   logic [rcka_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [rcka_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   rgb_color_key_alpha_core DUT (.*);

   always #10 clock = ~clock;

   // key setting mirrored in the testbench
   logic [7:0]  key_r, key_g, key_b;
   logic [11:0] tol;
   logic [10:0] fea;
   logic [6:0]  spill_pct;

   rcka_pkg::req_beat_type pixel_q[$];
   rcka_pkg::rsp_beat_type keyed_q[$];
   int errors = 0;
   int wdog = 0;
   bit drive_on = 1'b0;
   bit stall_on = 1'b0;

   function automatic logic [31:0] root32(logic [31:0] v);
      logic [31:0] res, bits;
      res = 0;
      bits = 32'h4000_0000;
      while (bits > v) bits = bits >> 2;
      while (bits != 0) begin
         if (v >= res + bits) begin
            v = v - (res + bits);
            res = (res >> 1) + bits;
         end else begin
            res = res >> 1;
         end
         bits = bits >> 2;
      end
      return res;
   endfunction

   function automatic logic [7:0] pull_chan(longint c, longint sum, longint desat);
      longint num, v;
      num = c * 3 * 65536 + (sum - 3 * c) * desat;
      if (num < 0) num = 0;
      v = num / (3 * 65536);
      if (v > 255) v = 255;
      return v[7:0];
   endfunction

   function automatic rcka_pkg::rsp_beat_type key_pixel(rcka_pkg::req_beat_type px);
      rcka_pkg::rsp_beat_type o;
      longint r, g, b, dr, dg, db, dist_v, lo, hi, alpha, pct, mx, mn;
      longint sat, spl, ss, desat, sum;
      r = px.red_in; g = px.green_in; b = px.blue_in;
      dr = r - key_r; dg = g - key_g; db = b - key_b;
      dist_v = root32(32'((dr * dr + dg * dg + db * db) * 256));
      lo = longint'(tol) - longint'(fea);
      hi = longint'(tol) + longint'(fea);
      pct = (spill_pct > 100) ? 100 : spill_pct;
      if (dist_v <= lo) alpha = 0;
      else if (dist_v <= hi && fea != 0) begin
         alpha = ((dist_v - lo) << 16) / (2 * longint'(fea));
         if (alpha > 65536) alpha = 65536;
      end else alpha = 65536;
      if (pct > 0 && alpha < 65536) begin
         mx = r; mn = r;
         if (g > mx) mx = g;
         if (b > mx) mx = b;
         if (g < mn) mn = g;
         if (b < mn) mn = b;
         if (mx > 0 && (mx - mn) * 10 > mx) begin
            sat = ((mx - mn) << 16) / mx;
            spl = (pct << 16) / 100;
            ss = (sat * spl) >> 16;
            desat = (ss * (65536 - alpha)) >> 16;
            sum = r + g + b;
            r = pull_chan(r, sum, desat);
            g = pull_chan(g, sum, desat);
            b = pull_chan(b, sum, desat);
         end
      end
      o.red_out = r[7:0]; o.green_out = g[7:0]; o.blue_out = b[7:0];
      o.alpha_out = 8'((alpha * 255) >> 16);
      return o;
   endfunction

   // driver: bursts and gaps
   int burst_left = 0, gap_left = 0;
   always @(posedge clock) begin
      if (req_valid && req_ready) begin
         keyed_q.push_back(key_pixel(req_beat));
      end
      if (!req_valid || req_ready) begin
         if (drive_on && pixel_q.size() > 0 && gap_left == 0) begin
            req_valid <= 1'b1;
            req_beat <= pixel_q.pop_front();
            if (burst_left == 0) begin
               burst_left <= $urandom_range(1, 30);
            end else if (burst_left == 1) begin
               burst_left <= 0;
               gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
            if (gap_left > 0) gap_left <= gap_left - 1;
         end
      end
   end

   // monitor with its own stall pattern
   int stall_phase = 0;
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1;
      if (!stall_on) rsp_ready <= 1'b1;
      else if (stall_phase[7:6] == 2'd0) rsp_ready <= 1'b1;
      else rsp_ready <= ($urandom_range(0, 3) != 0);
      if (!reset && rsp_valid && rsp_ready) begin
         if (keyed_q.size() == 0) begin
            $error("unexpected rsp beat %h", rsp_beat);
            errors++;
         end else begin
            rcka_pkg::rsp_beat_type e;
            e = keyed_q.pop_front();
            if (e.red_out !== rsp_beat.red_out) begin
               $error("red_out exp %0d got %0d", e.red_out, rsp_beat.red_out); errors++;
            end
            if (e.green_out !== rsp_beat.green_out) begin
               $error("green_out exp %0d got %0d", e.green_out, rsp_beat.green_out); errors++;
            end
            if (e.blue_out !== rsp_beat.blue_out) begin
               $error("blue_out exp %0d got %0d", e.blue_out, rsp_beat.blue_out); errors++;
            end
            if (e.alpha_out !== rsp_beat.alpha_out) begin
               $error("alpha_out exp %0d got %0d", e.alpha_out, rsp_beat.alpha_out); errors++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) wdog <= 0;
      else wdog <= wdog + 1;
      if (wdog >= WDOG_MAX) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic write_reg(rcka_pkg::csr_index_type idx,
                            logic [rcka_pkg::CSR_DATA_W-1:0] val);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         rcka_pkg::CSR_KEY_RED:   key_r = val[7:0];
         rcka_pkg::CSR_KEY_GREEN: key_g = val[7:0];
         rcka_pkg::CSR_KEY_BLUE:  key_b = val[7:0];
         rcka_pkg::CSR_TOLERANCE: tol = val[11:0];
         rcka_pkg::CSR_FEATHER:   fea = val[10:0];
         rcka_pkg::CSR_SPILL:     spill_pct = val[6:0];
         default: ;
      endcase
   endtask

   task automatic run_pixels();
      drive_on = 1'b1;
      while (pixel_q.size() > 0 || req_valid || keyed_q.size() > 0) @(posedge clock);
      drive_on = 1'b0;
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic add_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      rcka_pkg::req_beat_type p;
      p.red_in = r; p.green_in = g; p.blue_in = b;
      pixel_q.push_back(p);
   endtask

   task automatic rand_near_key(int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 2) == 0) add_pixel(8'($urandom), 8'($urandom), 8'($urandom));
         else add_pixel(8'(key_r + $urandom_range(0, 60) - 30),
                        8'(key_g + $urandom_range(0, 60) - 30),
                        8'(key_b + $urandom_range(0, 60) - 30));
      end
   endtask

   initial begin
      key_r = 0; key_g = 255; key_b = 0; tol = 400; fea = 0; spill_pct = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // defaults, then extremes and special cases
      add_pixel(0, 255, 0); add_pixel(0, 0, 0); add_pixel(255, 255, 255);
      add_pixel(255, 0, 255); add_pixel(10, 230, 20);
      run_pixels();
      write_reg(rcka_pkg::CSR_SPILL, 100); write_reg(rcka_pkg::CSR_FEATHER, 300);
      write_reg(rcka_pkg::CSR_TOLERANCE, 100);      // tolerance below feather
      add_pixel(0, 255, 0); add_pixel(5, 250, 3); add_pixel(40, 200, 30);
      add_pixel(0, 0, 0); add_pixel(100, 100, 100); add_pixel(255, 0, 0);
      run_pixels();
      write_reg(rcka_pkg::CSR_SPILL, 127);          // saturated to 100
      write_reg(rcka_pkg::CSR_FEATHER, 2047); write_reg(rcka_pkg::CSR_TOLERANCE, 4095);
      write_reg(rcka_pkg::CSR_KEY_RED, 255); write_reg(rcka_pkg::CSR_KEY_GREEN, 0);
      write_reg(rcka_pkg::CSR_KEY_BLUE, 255);
      add_pixel(255, 0, 255); add_pixel(0, 255, 0); add_pixel(200, 20, 180);
      add_pixel(0, 0, 0); add_pixel(1, 1, 1);
      run_pixels();
      write_reg(rcka_pkg::csr_index_type'(3'd6), 12'hfff);   // unused index
      write_reg(rcka_pkg::csr_index_type'(3'd7), 12'h000);
      add_pixel(128, 128, 128);
      run_pixels();
      // random phases
      stall_on = 1'b1;
      for (int ph = 0; ph < 12; ph++) begin
         write_reg(rcka_pkg::CSR_KEY_RED, 12'($urandom));
         write_reg(rcka_pkg::CSR_KEY_GREEN, 12'($urandom));
         write_reg(rcka_pkg::CSR_KEY_BLUE, 12'($urandom));
         case (ph % 4)
            0: write_reg(rcka_pkg::CSR_TOLERANCE, 12'($urandom_range(0, 800)));
            1: write_reg(rcka_pkg::CSR_TOLERANCE, 12'($urandom));
            2: write_reg(rcka_pkg::CSR_TOLERANCE, 0);
            default: write_reg(rcka_pkg::CSR_TOLERANCE, 4080);
         endcase
         case (ph % 3)
            0: write_reg(rcka_pkg::CSR_FEATHER, 0);
            1: write_reg(rcka_pkg::CSR_FEATHER, 12'($urandom_range(1, 600)));
            default: write_reg(rcka_pkg::CSR_FEATHER, 12'($urandom));
         endcase
         write_reg(rcka_pkg::CSR_SPILL, (ph % 5 == 0) ? 12'd0 : 12'($urandom));
         rand_near_key(75);
         run_pixels();
      end
      if (errors == 0 && keyed_q.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ===== rgb_color_key_alpha_core.f =====
+incdir+hw/rtl
hw/rtl/rcka_pkg.sv
hw/rtl/rcka_isqrt.sv
hw/rtl/rcka_frac_div.sv
hw/rtl/rgb_color_key_alpha_core.sv
verif/tb.sv
